// ===== design/fcirc_pkg.sv =====
// Shared types and constants for the circular-buffer FIR filter.
// Used by every module of the block; depends on nothing.
package fcirc_pkg;

    localparam int DATA_W    = 32;
    localparam int TAP_IDX_W = 7;
    localparam int COUNT_W   = 8;
    localparam int TDATA_W   = 40;

    // Item kinds carried in the input tuser bit.
    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } fcirc_state_t;

    // Strobes from the sequencer to the sample and coefficient stores.
    typedef struct packed {
        logic hist_we;
        logic coef_we;
        logic rd_en;
    } fcirc_mem_ctl_t;

endpackage

// ===== design/fcirc_store.sv =====
// Sample history and coefficient memories, one write and one read port each.
// Depends on fcirc_pkg.
module fcirc_store #(
    parameter int TAPS = 128,
    parameter int AW   = 7
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  fcirc_pkg::fcirc_mem_ctl_t      ctl,
    input  logic [AW-1:0]                  hist_waddr,
    input  logic [fcirc_pkg::DATA_W-1:0]   hist_wdata,
    input  logic [AW-1:0]                  coef_waddr,
    input  logic [fcirc_pkg::DATA_W-1:0]   coef_wdata,
    input  logic [AW-1:0]                  hist_raddr,
    input  logic [AW-1:0]                  coef_raddr,
    output logic [fcirc_pkg::DATA_W-1:0]   hist_rdata,
    output logic [fcirc_pkg::DATA_W-1:0]   coef_rdata,
    output logic                           rd_valid
);
    import fcirc_pkg::*;

    logic [DATA_W-1:0] hist_mem [TAPS];
    logic [DATA_W-1:0] coef_mem [TAPS];
    logic [DATA_W-1:0] hist_rdata_reg;
    logic [DATA_W-1:0] coef_rdata_reg;
    logic              rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.hist_we)
        begin
            hist_mem[hist_waddr] <= hist_wdata;
        end
        if (ctl.coef_we)
        begin
            coef_mem[coef_waddr] <= coef_wdata;
        end
        if (ctl.rd_en)
        begin
            hist_rdata_reg <= hist_mem[hist_raddr];
            coef_rdata_reg <= coef_mem[coef_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= ctl.rd_en;
        end
    end

    assign hist_rdata = hist_rdata_reg;
    assign coef_rdata = coef_rdata_reg;
    assign rd_valid   = rd_valid_reg;

endmodule

// ===== design/fcirc_mac.sv =====
// Shared multiply-accumulate unit: a registered 32x32 product, then a wrapping sum.
// Depends on fcirc_pkg.
module fcirc_mac (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           clear,
    input  logic                           in_valid,
    input  logic [fcirc_pkg::DATA_W-1:0]   sample,
    input  logic [fcirc_pkg::DATA_W-1:0]   coef,
    output logic [fcirc_pkg::DATA_W-1:0]   acc,
    output logic                           busy
);
    import fcirc_pkg::*;

    logic [DATA_W-1:0] prod_reg;
    logic [DATA_W-1:0] prod_next;
    logic              prod_valid_reg;
    logic [DATA_W-1:0] acc_reg;

    // Only the low 32 bits matter; they are the same for signed and unsigned operands.
    assign prod_next = sample * coef;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            prod_reg <= prod_next;
        end
        if (clear)
        begin
            acc_reg <= '0;
        end
        else if (prod_valid_reg)
        begin
            acc_reg <= acc_reg + prod_reg;
        end
    end

    assign acc  = acc_reg;
    assign busy = in_valid | prod_valid_reg;

endmodule

// ===== design/fcirc_ctrl.sv =====
// Sequencer: clearing sweep, item decode, write pointer and tap walk.
// Depends on fcirc_pkg.
module fcirc_ctrl #(
    parameter int TAPS = 128,
    parameter int AW   = 7
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              in_action,
    input  logic [fcirc_pkg::TAP_IDX_W-1:0]   in_tap_index,
    input  logic [fcirc_pkg::DATA_W-1:0]      in_value,
    input  logic [fcirc_pkg::COUNT_W-1:0]     tap_count,
    input  logic                              out_free,
    input  logic                              mac_busy,
    output logic                              mac_clear,
    output logic                              res_load,
    output fcirc_pkg::fcirc_mem_ctl_t         mem_ctl,
    output logic [AW-1:0]                     hist_waddr,
    output logic [fcirc_pkg::DATA_W-1:0]      hist_wdata,
    output logic [AW-1:0]                     coef_waddr,
    output logic [fcirc_pkg::DATA_W-1:0]      coef_wdata,
    output logic [AW-1:0]                     hist_raddr,
    output logic [AW-1:0]                     coef_raddr
);
    import fcirc_pkg::*;

    localparam int OW  = $clog2(TAPS + 1);
    localparam int OW2 = (OW > COUNT_W) ? OW : COUNT_W;
    localparam int SW  = AW + 2;

    fcirc_state_t  state_reg, state_next;
    logic [AW-1:0] wp_reg, wp_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [AW-1:0] pos_reg, pos_next;
    logic [OW-1:0] cnt_reg, cnt_next;
    logic [OW-1:0] order_reg, order_next;

    logic [OW-1:0] order_now;
    logic [SW-1:0] start_sum;
    logic [AW-1:0] start_pos;
    logic          tap_ok;
    logic          accept;

    // Tap counts above the store depth saturate.
    assign order_now = (OW2'(tap_count) > OW2'(TAPS)) ? OW'(TAPS) : OW'(tap_count);

    // Oldest sample of the window: wp - order + 1, modulo TAPS.
    assign start_sum = SW'(wp_reg) + SW'(TAPS) + SW'(1) - SW'(order_now);
    assign start_pos = (start_sum >= SW'(TAPS)) ? AW'(start_sum - SW'(TAPS))
                                                : AW'(start_sum);

    assign tap_ok = int'(in_tap_index) < TAPS;
    assign accept = in_valid && in_ready;

    assign hist_raddr = pos_reg;
    assign coef_raddr = cnt_reg[AW-1:0];
    assign coef_waddr = AW'(in_tap_index);
    assign coef_wdata = in_value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            wp_reg    <= '0;
            clr_reg   <= '0;
            pos_reg   <= '0;
            cnt_reg   <= '0;
            order_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            wp_reg    <= wp_next;
            clr_reg   <= clr_next;
            pos_reg   <= pos_next;
            cnt_reg   <= cnt_next;
            order_reg <= order_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        wp_next     = wp_reg;
        clr_next    = clr_reg;
        pos_next    = pos_reg;
        cnt_next    = cnt_reg;
        order_next  = order_reg;
        in_ready    = 1'b0;
        mac_clear   = 1'b0;
        res_load    = 1'b0;
        mem_ctl     = '0;
        hist_waddr  = wp_reg;
        hist_wdata  = in_value;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_ctl.hist_we = 1'b1;
                hist_waddr      = clr_reg;
                hist_wdata      = '0;
                clr_next        = clr_reg + 1'b1;
                if (clr_reg == AW'(TAPS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_action == ACT_LOAD)
                    begin
                        mem_ctl.coef_we = tap_ok;
                    end
                    else
                    begin
                        mem_ctl.hist_we = 1'b1;
                        mac_clear       = 1'b1;
                        order_next      = order_now;
                        pos_next        = start_pos;
                        cnt_next        = '0;
                        wp_next         = (wp_reg == AW'(TAPS - 1)) ? '0 : wp_reg + 1'b1;
                        state_next      = (order_now == '0) ? ST_DRAIN : ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                mem_ctl.rd_en = 1'b1;
                pos_next      = (pos_reg == AW'(TAPS - 1)) ? '0 : pos_reg + 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == order_reg - 1'b1)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!mac_busy && out_free)
                begin
                    res_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    a_run_after_sample: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_action == ACT_SAMPLE && order_now != '0) |=> state_reg == ST_RUN)
        else $error("sample with taps in use did not start the tap walk");

    a_cnt_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RUN |-> cnt_reg < order_reg)
        else $error("tap counter ran past the filter order");

    a_load_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> (!mac_busy && !mem_ctl.rd_en))
        else $error("result taken while products still in flight");

    a_wp_range: assert property (@(posedge clk) disable iff (!rst_n)
        int'(wp_reg) < TAPS)
        else $error("write pointer left the sample store");

endmodule

// ===== design/fir_filter_circular.sv =====
// Circular-buffer FIR filter: one input transaction per coefficient or sample.
// Each sample is filtered over order taps, where order is tap_count saturated to TAPS;
// order 0 skips the tap walk. The single shared multiply-accumulate unit takes one tap
// per cycle from one read port of each memory, and a new transaction is taken only once
// the last result is in the output register. Reset: asynchronous, active low; a clearing
// sweep then zeroes the samples.
module fir_filter_circular #(
    parameter int TAPS = 128
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Input stream.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [fcirc_pkg::TDATA_W-1:0]      s_tdata,   // [6:0] tap_index, [38:7] value
    input  logic [0:0]                         s_tuser,   // [0] action
    // Result stream.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [fcirc_pkg::DATA_W-1:0]       m_tdata,   // [31:0] filtered
    // Tap count write channel.
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [fcirc_pkg::COUNT_W-1:0]      cfg_data
);
    import fcirc_pkg::*;

    localparam int AW = $clog2(TAPS);

    // The tap count register. Writes must arrive only while the filter is idle;
    // the block itself does not enforce it, and the channel is always ready.
    logic [COUNT_W-1:0] tap_count_reg;

    // Output register: a finished result waits here while the next
    // transaction is already accepted.
    logic               out_valid_reg;
    logic [DATA_W-1:0]  out_data_reg;
    logic               out_free;

    logic                  in_action;
    logic [TAP_IDX_W-1:0]  in_tap_index;
    logic [DATA_W-1:0]     in_value;

    fcirc_mem_ctl_t     mem_ctl;
    logic [AW-1:0]      hist_waddr;
    logic [DATA_W-1:0]  hist_wdata;
    logic [AW-1:0]      coef_waddr;
    logic [DATA_W-1:0]  coef_wdata;
    logic [AW-1:0]      hist_raddr;
    logic [AW-1:0]      coef_raddr;
    logic [DATA_W-1:0]  hist_rdata;
    logic [DATA_W-1:0]  coef_rdata;
    logic               rd_valid;

    logic               mac_clear;
    logic               mac_busy;
    logic [DATA_W-1:0]  acc;
    logic               res_load;

    // Unpack the input transaction. Bit 39 of tdata is padding.
    assign in_action    = s_tuser[0];
    assign in_tap_index = s_tdata[TAP_IDX_W-1:0];
    assign in_value     = s_tdata[TAP_IDX_W+DATA_W-1:TAP_IDX_W];

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || m_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                tap_count_reg <= cfg_data;
            end
            if (res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            out_data_reg <= acc;
        end
    end

    // The sequencer walks the window one tap per cycle, oldest sample first,
    // pairing it with coefficients 0 up to order - 1.
    fcirc_ctrl #(
        .TAPS (TAPS),
        .AW   (AW)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_action    (in_action),
        .in_tap_index (in_tap_index),
        .in_value     (in_value),
        .tap_count    (tap_count_reg),
        .out_free     (out_free),
        .mac_busy     (mac_busy),
        .mac_clear    (mac_clear),
        .res_load     (res_load),
        .mem_ctl      (mem_ctl),
        .hist_waddr   (hist_waddr),
        .hist_wdata   (hist_wdata),
        .coef_waddr   (coef_waddr),
        .coef_wdata   (coef_wdata),
        .hist_raddr   (hist_raddr),
        .coef_raddr   (coef_raddr)
    );

    fcirc_store #(
        .TAPS (TAPS),
        .AW   (AW)
    ) u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (mem_ctl),
        .hist_waddr (hist_waddr),
        .hist_wdata (hist_wdata),
        .coef_waddr (coef_waddr),
        .coef_wdata (coef_wdata),
        .hist_raddr (hist_raddr),
        .coef_raddr (coef_raddr),
        .hist_rdata (hist_rdata),
        .coef_rdata (coef_rdata),
        .rd_valid   (rd_valid)
    );

    // Products keep their low 32 bits and the running sum wraps.
    fcirc_mac u_mac (
        .clk      (clk),
        .rst_n    (rst_n),
        .clear    (mac_clear),
        .in_valid (rd_valid),
        .sample   (hist_rdata),
        .coef     (coef_rdata),
        .acc      (acc),
        .busy     (mac_busy)
    );

endmodule

// ===== verif/tb_fir_filter_circular.sv =====
// Self-checking testbench for the circular-buffer FIR filter fir_filter_circular.
// Predicts each filtered output from its own sample ring and coefficient table.
// Depends on fcirc_pkg and the fir_filter_circular RTL only.
`timescale 1ns / 100ps

module tb_fir_filter_circular;

    import fcirc_pkg::*;

    localparam int TAPS        = 128;
    localparam int IDLE_MAX    = 14;
    // The slowest honest run stays well below this limit.
    localparam int CYCLE_LIMIT = 1_000_000;
    // Longest time the block may still be busy once the last result is out.
    localparam int SETTLE      = TAPS + 8;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [TDATA_W-1:0]   s_tdata;    // [6:0] tap_index, [38:7] value, [39] zero
    logic [0:0]           s_tuser;    // [0] action
    logic                 m_tvalid;
    logic                 m_tready;
    logic [DATA_W-1:0]    m_tdata;    // [31:0] filtered
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [COUNT_W-1:0]   cfg_data;

    fir_filter_circular #(
        .TAPS(TAPS)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    // Predictor state: the sample ring, the coefficient table, the write
    // pointer and the tap count as the block should hold them.
    logic [DATA_W-1:0]    sample_ring [TAPS];
    logic [DATA_W-1:0]    coef_table  [TAPS];
    int unsigned          ring_ptr;
    logic [COUNT_W-1:0]   tap_setting;

    // Filter outputs that have been predicted but not yet seen on m_tdata.
    logic [DATA_W-1:0]    filtered_q [$];

    int unsigned          mismatch_count;
    int unsigned          cycle_count;
    // When set, neither the sender nor the result sink inserts idle cycles.
    bit                   quiet;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles", cycle_count);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] want,
                                   input logic [DATA_W-1:0] got);
        // Keep the log short if the block is badly broken; every mismatch still counts.
        if (mismatch_count < 100)
        begin
            $display("%0t: %s: expected %h, got %h", $realtime, what, want, got);
        end
        mismatch_count++;
    endtask

    function automatic int unsigned idle_cycles();
        return quiet ? 0 : $urandom_range(0, IDLE_MAX);
    endfunction

    // Applies one accepted transaction to the predictor. A load only updates the
    // coefficient table; a sample goes into the ring and yields one filtered value,
    // the wrapped sum of the window (oldest first) times coefficients 0..order-1.
    task automatic predict_item(input logic act, input logic [TAP_IDX_W-1:0] idx,
                                input logic [DATA_W-1:0] val);
        int unsigned         order;
        int unsigned         pos;
        logic [DATA_W-1:0]   acc;
        if (act == ACT_LOAD)
        begin
            coef_table[idx] = val;
        end
        else
        begin
            sample_ring[ring_ptr] = val;
            // A tap count above the ring size behaves as the full ring.
            order = (tap_setting > TAPS) ? TAPS : tap_setting;
            pos   = (ring_ptr + TAPS + 1 - order) % TAPS;
            acc   = '0;
            for (int k = 0; k < order; k++)
            begin
                // Each product keeps only its low 32 bits, and so does the sum.
                acc = acc + sample_ring[pos] * coef_table[k];
                pos = (pos + 1) % TAPS;
            end
            ring_ptr = (ring_ptr + 1) % TAPS;
            filtered_q.push_back(acc);
        end
    endtask

    // Drives one transaction on the input stream after a random gap and waits for
    // the block to take it. Valid is left high so back-to-back items follow without a gap;
    // the next call with a gap, or the next idle point, lowers it.
    task automatic send_item(input logic act, input logic [TAP_IDX_W-1:0] idx,
                             input logic [DATA_W-1:0] val);
        int unsigned gap;
        gap = idle_cycles();
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = act;
        s_tdata  = {1'b0, val, idx};
        do
            @(posedge clk);
        while (!s_tready);
        predict_item(act, idx, val);
    endtask

    // Stops the input stream and waits until the block has nothing left to do.
    task automatic drain_block();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (filtered_q.size() != 0)
            @(posedge clk);
        // A trailing coefficient load gives no result, so allow for a full pass.
        repeat (SETTLE) @(posedge clk);
    endtask

    // Writes the tap count while the block is idle.
    task automatic set_tap_count(input logic [COUNT_W-1:0] count);
        drain_block();
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = count;
        do
            @(posedge clk);
        while (!cfg_ready);
        tap_setting = count;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Mostly random words, with the sign and magnitude extremes mixed in.
    function automatic logic [DATA_W-1:0] pick_value();
        logic [DATA_W-1:0] corner [5];
        corner = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff, 32'h0000_0001};
        if ($urandom_range(0, 7) == 0)
            return corner[$urandom_range(0, 4)];
        return $urandom;
    endfunction

    // Result sink: stalls a random number of cycles before each transaction.
    initial
    begin
        int unsigned stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = idle_cycles();
            if (stall > 0)
            begin
                @(negedge clk);
                m_tready = 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            m_tready = 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    // Output checker: every result transaction is matched against the oldest
    // prediction still waiting.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (filtered_q.size() == 0)
                report_mismatch("result with no sample pending", '0, m_tdata);
            else
            begin
                logic [DATA_W-1:0] want;
                want = filtered_q.pop_front();
                if (m_tdata !== want)
                    report_mismatch("filtered", want, m_tdata);
            end
        end
    end

    // After reset the tap count is zero, so every sample must give zero.
    task automatic test_reset_state();
        send_item(ACT_SAMPLE, 7'h7f, 32'h7fff_ffff);
        send_item(ACT_SAMPLE, 7'h00, 32'h8000_0000);
        send_item(ACT_SAMPLE, 7'h55, 32'h0000_0000);
    endtask

    // Two taps with extreme coefficients and samples; the first window also reaches
    // a ring slot that the reset-state test wrote before.
    task automatic test_extreme_products();
        set_tap_count(8'd2);
        send_item(ACT_LOAD, 7'd0,   32'h8000_0000);
        send_item(ACT_LOAD, 7'd1,   32'h7fff_ffff);
        send_item(ACT_LOAD, 7'd127, 32'hffff_ffff);
        send_item(ACT_SAMPLE, 7'd0,   32'h8000_0000);
        send_item(ACT_SAMPLE, 7'd127, 32'h8000_0000);
        send_item(ACT_SAMPLE, 7'd3,   32'h7fff_ffff);
        send_item(ACT_SAMPLE, 7'd64,  32'hffff_ffff);
        send_item(ACT_SAMPLE, 7'd1,   32'h0000_0001);
        send_item(ACT_SAMPLE, 7'd2,   32'h0000_0000);
        send_item(ACT_LOAD, 7'd1, 32'h0000_0001);
        send_item(ACT_SAMPLE, 7'd9, 32'h7fff_ffff);
        send_item(ACT_SAMPLE, 7'd9, 32'h8000_0000);
    endtask

    // Gives every coefficient a defined value before any longer filter reads it.
    task automatic test_coefficient_fill();
        for (int i = 0; i < TAPS; i++)
            send_item(ACT_LOAD, TAP_IDX_W'(i), pick_value());
    endtask

    // Random sample streams with occasional coefficient reloads at each tap count.
    task automatic run_stream(input int unsigned items);
        logic act;
        for (int i = 0; i < items; i++)
        begin
            if (i % 32 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            act = ($urandom_range(0, 99) < 15) ? ACT_LOAD : ACT_SAMPLE;
            send_item(act, TAP_IDX_W'($urandom_range(0, TAPS - 1)), pick_value());
        end
        quiet = 1'b0;
    endtask

    // Walks through short, long, full, saturated and zero tap counts. Long filters
    // are slow, so they get fewer items than the short ones.
    task automatic test_tap_counts();
        int unsigned taps_list  [14] = '{1, 2, 3, 5, 8, 12, 16, 33, 64, 127, 128, 129, 255, 0};
        int unsigned items_list [14] = '{110, 100, 100, 90, 90, 80, 80, 60, 40, 30, 30, 20,
                                         20, 50};
        for (int p = 0; p < 14; p++)
        begin
            set_tap_count(COUNT_W'(taps_list[p]));
            run_stream(items_list[p]);
        end
    endtask

    task automatic test_random_short_filters();
        for (int p = 0; p < 3; p++)
        begin
            set_tap_count(COUNT_W'($urandom_range(1, 10)));
            run_stream(35);
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = '0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        quiet          = 1'b0;
        mismatch_count = 0;
        ring_ptr       = 0;
        tap_setting    = '0;
        for (int i = 0; i < TAPS; i++)
        begin
            sample_ring[i] = '0;
            coef_table[i]  = '0;
        end
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_state();
        test_extreme_products();
        test_coefficient_fill();
        test_tap_counts();
        test_random_short_filters();

        drain_block();
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== sim.f =====
design/fcirc_pkg.sv
design/fcirc_store.sv
design/fcirc_mac.sv
design/fcirc_ctrl.sv
design/fir_filter_circular.sv
verif/tb_fir_filter_circular.sv
